/* src/frta_pkg.sv */
// Shared types and constants for the fractional rate tick accumulator.
`timescale 1ns / 1ps

package frta_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RateW  = 25;
  localparam int unsigned AccumW = 33;
  localparam int unsigned IvlW   = 25;
  localparam int unsigned CountW = 6;

  // Rate at or above this (100000 Hz in Q17.8) means an update every frame.
  localparam logic [RateW-1:0] RateAlways = RateW'(25600000);
  // Lowest rate used for the interval (1.0 Hz in Q17.8).
  localparam logic [RateW-1:0] RateFloor  = RateW'(256);
  // Number of restoring-divide steps over the 33-bit dividend.
  localparam logic [CountW-1:0] DivSteps  = CountW'(AccumW);
  // Dividend of the interval divide: 2^32.
  localparam logic [AccumW-1:0] IvlDividend = {1'b1, {(AccumW-1){1'b0}}};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_SUM,
    ST_MOD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clear_acc;
    logic start_div;
    logic start_mod;
    logic step;
    logic take_ivl;
    logic store_sum;
    logic store_diff;
    logic store_rem;
    logic set_due;
    logic clr_due;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic always_hit;
    logic div_done;
    logic sum_below;
    logic diff_below;
  } status_t;

endpackage

/* src/fractional_rate_tick_accumulator.sv */
// Steps: a word at 100 kHz and up goes from classify straight to its result; any other
// word runs the interval divide and the sum, plus a remainder divide when the sum needs it.
// Flow: one word at a time; the next word is taken no earlier than the cycle after the result
// leaves, and the 33-step restoring divider is shared by both divides.
// Reset (synchronous, active high) clears the time accumulator and returns to idle.
`timescale 1ns / 1ps

module fractional_rate_tick_accumulator import frta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [TimeW-1:0] frame_time,
  input  logic [RateW-1:0] rate_hz,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             update_due
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  frta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  frta_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .frame_time (frame_time),
    .rate_hz    (rate_hz),
    .status     (status),
    .update_due (update_due)
  );

endmodule

/* src/frta_dp.sv */
// Datapath: input capture, shared restoring divider, accumulator and result flag.
`timescale 1ns / 1ps

module frta_dp import frta_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [TimeW-1:0]  frame_time,
  input  logic [RateW-1:0]  rate_hz,
  output status_t           status,
  output logic              update_due
);

  logic [TimeW-1:0]  dt;
  logic [RateW-1:0]  rate;
  logic [AccumW-1:0] accum;
  logic [IvlW-1:0]   ivl;
  logic [IvlW-1:0]   divisor;
  logic [IvlW-1:0]   rem;
  logic [AccumW-1:0] dq;
  logic [CountW-1:0] count;
  logic              due;

  logic [IvlW:0]     rem_sh;
  logic              rem_ge;
  logic [IvlW:0]     rem_sub;
  logic [AccumW-1:0] sum;
  logic [AccumW-1:0] diff;
  logic [AccumW-1:0] ivl_ext;
  logic [RateW-1:0]  rate_clamped;

  // Divider step: shift in the next dividend bit and try one subtraction.
  always_comb begin
    rem_sh  = {rem, dq[AccumW-1]};
    rem_ge  = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // Accumulator sum and the sum after one interval is consumed.
  always_comb begin
    ivl_ext      = {{(AccumW-IvlW){1'b0}}, ivl};
    sum          = accum + {{(AccumW-TimeW){1'b0}}, dt};
    diff         = sum - ivl_ext;
    rate_clamped = (rate < RateFloor) ? RateFloor : rate;
  end

  // Status toward the controller.
  always_comb begin
    status.always_hit = (rate >= RateAlways);
    status.div_done   = (count == '0);
    status.sum_below  = (sum < ivl_ext);
    status.diff_below = (diff < ivl_ext);
  end

  // Input capture and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt   <= frame_time;
      rate <= rate_hz;
    end
    if (cmd.start_div) begin
      dq      <= IvlDividend;
      rem     <= '0;
      divisor <= rate_clamped;
      count   <= DivSteps;
    end else if (cmd.start_mod) begin
      dq      <= diff;
      rem     <= '0;
      divisor <= ivl;
      count   <= DivSteps;
    end else if (cmd.step) begin
      dq    <= {dq[AccumW-2:0], rem_ge};
      rem   <= rem_ge ? rem_sub[IvlW-1:0] : rem_sh[IvlW-1:0];
      count <= count - CountW'(1);
    end
    if (cmd.take_ivl) begin
      ivl <= dq[IvlW-1:0];
    end
  end

  // Kept time accumulator and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      due   <= 1'b0;
    end else begin
      if (cmd.clear_acc) begin
        accum <= '0;
      end else if (cmd.store_sum) begin
        accum <= sum;
      end else if (cmd.store_diff) begin
        accum <= diff;
      end else if (cmd.store_rem) begin
        accum <= {{(AccumW-IvlW){1'b0}}, rem};
      end
      if (cmd.set_due) begin
        due <= 1'b1;
      end else if (cmd.clr_due) begin
        due <= 1'b0;
      end
    end
  end

  assign update_due = due;

endmodule

/* src/frta_ctrl.sv */
// Controller: sequences interval divide, accumulate and remainder steps per word.
`timescale 1ns / 1ps

module frta_ctrl import frta_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        state_next = status.always_hit ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (status.sum_below || status.diff_below) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_CLASSIFY: begin
        if (status.always_hit) begin
          cmd.clear_acc = 1'b1;
          cmd.set_due   = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.take_ivl = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SUM: begin
        if (status.sum_below) begin
          cmd.store_sum = 1'b1;
          cmd.clr_due   = 1'b1;
        end else if (status.diff_below) begin
          cmd.store_diff = 1'b1;
          cmd.set_due    = 1'b1;
        end else begin
          cmd.start_mod = 1'b1;
        end
      end
      ST_MOD: begin
        if (status.div_done) begin
          cmd.store_rem = 1'b1;
          cmd.set_due   = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* bench/fractional_rate_tick_accumulator_test.sv */
// Self-checking testbench for the fractional rate tick accumulator.
`timescale 1ns / 1ps

module fractional_rate_tick_accumulator_test;
  import frta_pkg::*;

  localparam int IdleLimit    = 3000;
  localparam int RandomFrames = 1250;
  localparam int SettleCycles = 80;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [TimeW-1:0] frame_time;
  logic [RateW-1:0] rate_hz;
  logic             out_valid;
  logic             out_stall;
  logic             update_due;

  // Predicted accumulator and the queue of update flags still owed by the block.
  logic [AccumW-1:0] tick_accum;
  logic              pending_due[$];

  // While steady is set, neither side inserts idle cycles.
  logic steady;
  int   mismatches;
  int   frames_sent;
  int   results_seen;
  int   updates_seen;
  int   wrap_frames;
  int   every_frame_hits;
  int   idle_cycles;

  fractional_rate_tick_accumulator u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_time (frame_time),
    .rate_hz    (rate_hz),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .update_due (update_due)
  );

  // Free-running 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Update interval in Q24 seconds for a Q17.8 rate, floored at 1 Hz.
  function automatic logic [AccumW-1:0] frame_interval(input logic [RateW-1:0] rate);
    logic [63:0] divisor;
    divisor = (rate < RateFloor) ? 64'(RateFloor) : 64'(rate);
    return AccumW'((64'd1 << 32) / divisor);
  endfunction

  // Advances the predicted accumulator by one frame and returns the update flag.
  function automatic logic advance_accum(input logic [TimeW-1:0] dt,
                                         input logic [RateW-1:0] rate);
    logic [63:0] ivl;
    logic [63:0] total;
    if (rate >= RateAlways) begin
      tick_accum = '0;
      every_frame_hits++;
      return 1'b1;
    end
    ivl   = 64'(frame_interval(rate));
    total = 64'(tick_accum) + 64'(dt);
    if (total < ivl) begin
      tick_accum = AccumW'(total);
      return 1'b0;
    end
    total = total - ivl;
    if (total >= ivl) begin
      total = total % ivl;
      wrap_frames++;
    end
    tick_accum = AccumW'(total);
    return 1'b1;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Offers one word, optionally after an idle gap, and records its prediction.
  task automatic send_frame(input logic [TimeW-1:0] dt, input logic [RateW-1:0] rate);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 10) gap = $urandom_range(1, 80);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    frame_time = dt;
    rate_hz    = rate;
    do @(posedge clk); while (in_stall);
    pending_due.push_back(advance_accum(dt, rate));
    frames_sent++;
  endtask

  // Drops valid so the last word is not offered again.
  task automatic hold_off();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random rate: mostly ordinary rates, with the floor, the ceiling and full range mixed in.
  function automatic logic [RateW-1:0] pick_rate();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return RateW'($urandom_range(256, 256000));
    if (pick < 60) return RateW'($urandom_range(0, 255));
    if (pick < 70) return RateW'($urandom_range(256000, 25599999));
    if (pick < 80) return RateW'($urandom_range(25600000, 33554431));
    if (pick < 90) return RateW'($urandom);
    return RateW'($urandom_range(25599990, 25600010));
  endfunction

  // Random frame time scaled to the interval, so updates come and go.
  function automatic logic [TimeW-1:0] pick_frame_time(input logic [AccumW-1:0] ivl);
    int          pick;
    logic [63:0] span;
    pick = $urandom_range(99);
    span = 64'(ivl);
    if (pick < 55) return TimeW'($urandom_range(0, int'(span * 3 / 2)));
    if (pick < 70) return TimeW'(span * $urandom_range(2, 8) + $urandom_range(0, 3));
    if (pick < 80) return TimeW'($urandom);
    if (pick < 90) return TimeW'(span + $urandom_range(0, 2) - 1);
    if (pick < 95) return '0;
    return TimeW'($urandom & $urandom);
  endfunction

  // Receiver stalls at random outside the steady stretch.
  always @(negedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < 10);
  end

  // Compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        if (update_due !== pending_due[0]) begin
          report_mismatch($sformatf("result %0d update_due got %b, expected %b",
                                    results_seen, update_due, pending_due[0]));
        end
        void'(pending_due.pop_front());
      end
      if (update_due === 1'b1) updates_seen++;
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no word moved for %0d cycles", IdleLimit);
        $display("fractional_rate_tick_accumulator_test: FAIL");
        $finish;
      end
    end
  end

  // Rate extremes: below the floor, at the floor, just under, at and above the every-frame rate.
  task automatic test_rate_extremes();
    send_frame(32'h0000_0000, 25'd0);
    send_frame(32'h00FF_FFFF, 25'd255);
    send_frame(32'h0000_0001, 25'd255);
    send_frame(32'h0100_0000, 25'd256);
    send_frame(32'hFFFF_FFFF, 25'd25599999);
    send_frame(32'hFFFF_FFFF, 25'd25600000);
    send_frame(32'h0000_0000, 25'h1FF_FFFF);
    send_frame(32'h0000_0000, 25'd256);
  endtask

  // Boundaries of the interval: just below, exact, twice and many times over.
  task automatic test_interval_edges();
    logic [AccumW-1:0] ivl;
    ivl = frame_interval(25'd15360);
    send_frame(TimeW'(ivl - 1), 25'd15360);
    send_frame(32'h0000_0001, 25'd15360);
    send_frame(TimeW'(ivl * 2), 25'd15360);
    send_frame(TimeW'(ivl * 3 + 5), 25'd15360);
    send_frame(32'h0000_0000, 25'd15360);
    send_frame(32'hFFFF_FFFF, 25'd256);
    send_frame(32'hAAAA_AAAA, 25'h155_5555);
    send_frame(32'h5555_5555, 25'h0AA_AAAA);
    send_frame(32'h0000_00A7, 25'd25599999);
    send_frame(32'h0000_00A6, 25'd25599999);
  endtask

  // Sender holds off until every result is back, then resumes.
  task automatic test_drain_pause();
    repeat (12) send_frame(pick_frame_time(frame_interval(25'd7680)), 25'd7680);
    hold_off();
    while (pending_due.size() != 0) @(posedge clk);
    repeat (12) send_frame(pick_frame_time(frame_interval(25'd7680)), 25'd7680);
  endtask

  // Runs of frames at one rate with random timing, plus stray rates as noise.
  task automatic test_random_frames();
    int                count;
    int                run_len;
    logic [RateW-1:0]  run_rate;
    logic [RateW-1:0]  rate;
    count = 0;
    while (count < RandomFrames) begin
      run_rate = pick_rate();
      run_len  = $urandom_range(4, 30);
      repeat (run_len) begin
        steady = (count >= 500 && count < 700);
        rate   = ($urandom_range(99) < 10) ? pick_rate() : run_rate;
        send_frame(pick_frame_time(frame_interval(rate)), rate);
        count++;
      end
    end
    steady = 1'b0;
  endtask

  // Reset, directed checks, random traffic, drain and verdict.
  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    frame_time       = '0;
    rate_hz          = '0;
    out_stall        = 1'b0;
    steady           = 1'b0;
    tick_accum       = '0;
    mismatches       = 0;
    frames_sent      = 0;
    results_seen     = 0;
    updates_seen     = 0;
    wrap_frames      = 0;
    every_frame_hits = 0;
    idle_cycles      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_rate_extremes();
    test_interval_edges();
    test_drain_pause();
    test_random_frames();

    hold_off();
    while (pending_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d frames and checked %0d results, %0d with an update due.",
             frames_sent, results_seen, updates_seen);
    $display("Remainder wraps: %0d; frames at the every-frame rate: %0d.",
             wrap_frames, every_frame_hits);
    if (mismatches == 0 && pending_due.size() == 0) begin
      $display("fractional_rate_tick_accumulator_test: PASS");
    end else begin
      $display("fractional_rate_tick_accumulator_test: FAIL");
    end
    $finish;
  end

endmodule

/* fractional_rate_tick_accumulator.f */
src/frta_pkg.sv
src/frta_dp.sv
src/frta_ctrl.sv
src/fractional_rate_tick_accumulator.sv
bench/fractional_rate_tick_accumulator_test.sv
